// ===== sv/lsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helper functions for the level-set upwind point update.
// No dependencies; imported by every module of the block.
package lsu_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_INV_DX      = 2'd0;
  localparam logic [1:0] REG_INV_DY      = 2'd1;
  localparam logic [1:0] REG_TIME_STEP   = 2'd2;
  localparam logic [1:0] REG_FLAME_SPEED = 2'd3;

  // Register reset values.
  localparam logic [30:0] RST_INV_DX      = 31'd65536;
  localparam logic [30:0] RST_INV_DY      = 31'd65536;
  localparam logic [30:0] RST_TIME_STEP   = 31'd655;
  localparam logic [31:0] RST_FLAME_SPEED = 32'd65536;

  // Square root pipeline: 32 iterations spread over the stages.
  localparam int ISQ_STAGES = 8;
  localparam int ISQ_PER    = 4;
  // Divider pipeline: 32 quotient bits spread over the stages.
  localparam int DIV_STAGES = 8;
  localparam int DIV_PER    = 4;

  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;
  localparam logic [63:0] HI_LIMIT  = 64'h1_0000_0000;
  localparam logic [63:0] STEP_CAP  = 64'h2_0000_0000;
  localparam logic signed [35:0] W36_MAX = 36'sd2147483647;
  localparam logic signed [35:0] W36_MIN = -36'sd2147483648;

  // Magnitude of a 33-bit two's complement value.
  function automatic logic [32:0] abs33(logic [32:0] v);
    return v[32] ? (33'd0 - v) : v;
  endfunction

  // Magnitude of a 32-bit two's complement value (2^31 fits unsigned).
  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Clip a wide signed value to 32 bits; the top bit reports a clip.
  function automatic logic [32:0] sat32(logic signed [35:0] v);
    logic [32:0] res;
    if (v > W36_MAX) begin
      res = {1'b1, S32_MAX};
    end else if (v < W36_MIN) begin
      res = {1'b1, S32_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

// ===== sv/lsu_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined floor square root of a 64-bit radicand, a few iterations per stage.
// Depends on lsu_pkg for the stage counts.
module lsu_isqrt import lsu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] x_r   [ISQ_STAGES];
  logic [63:0] r_r   [ISQ_STAGES];
  logic [63:0] x_in  [ISQ_STAGES];
  logic [63:0] r_in  [ISQ_STAGES];
  logic [63:0] x_nxt [ISQ_STAGES];
  logic [63:0] r_nxt [ISQ_STAGES];

  always_comb begin
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x_in[0] = rad;
    r_in[0] = '0;
    for (int s = 1; s < ISQ_STAGES; s++) begin
      x_in[s] = x_r[s-1];
      r_in[s] = r_r[s-1];
    end
    for (int s = 0; s < ISQ_STAGES; s++) begin
      x = x_in[s];
      r = r_in[s];
      for (int k = 0; k < ISQ_PER; k++) begin
        b = 64'd1 << (62 - 2 * (s * ISQ_PER + k));
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      x_nxt[s] = x;
      r_nxt[s] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ISQ_STAGES; s++) begin
        x_r[s] <= x_nxt[s];
        r_r[s] <= r_nxt[s];
      end
    end
  end

  assign root = r_r[ISQ_STAGES-1][31:0];

endmodule

// ===== sv/lsu_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: 64-bit numerator by 32-bit divisor, 32-bit quotient.
// Depends on lsu_pkg; the caller keeps the quotient below 2^32.
module lsu_div import lsu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  logic [31:0] rem_r [DIV_STAGES];
  logic [31:0] q_r   [DIV_STAGES];
  logic [31:0] lo_r  [DIV_STAGES];
  logic [31:0] den_r [DIV_STAGES];
  logic [31:0] rem_in [DIV_STAGES];
  logic [31:0] q_in   [DIV_STAGES];
  logic [31:0] lo_in  [DIV_STAGES];
  logic [31:0] den_in [DIV_STAGES];
  logic [31:0] rem_nxt [DIV_STAGES];
  logic [31:0] q_nxt   [DIV_STAGES];
  logic [31:0] lo_nxt  [DIV_STAGES];

  always_comb begin
    logic [31:0] r;
    logic [31:0] q;
    logic [31:0] l;
    logic [32:0] t;
    rem_in[0] = num[63:32];
    q_in[0]   = '0;
    lo_in[0]  = num[31:0];
    den_in[0] = den;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s] = rem_r[s-1];
      q_in[s]   = q_r[s-1];
      lo_in[s]  = lo_r[s-1];
      den_in[s] = den_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem_in[s];
      q = q_in[s];
      l = lo_in[s];
      for (int k = 0; k < DIV_PER; k++) begin
        t = {r, l[31]};
        l = {l[30:0], 1'b0};
        if (t >= {1'b0, den_in[s]}) begin
          r = 32'(t - {1'b0, den_in[s]});
          q = {q[30:0], 1'b1};
        end else begin
          r = t[31:0];
          q = {q[30:0], 1'b0};
        end
      end
      rem_nxt[s] = r;
      q_nxt[s]   = q;
      lo_nxt[s]  = l;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        lo_r[s]  <= lo_nxt[s];
        den_r[s] <= den_in[s];
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

// ===== sv/level_set_upwind_point_update_core.sv =====
`timescale 1ns / 1ps
// Top level of the first-order upwind level-set point update pipeline.
// Depends on lsu_pkg, lsu_isqrt and lsu_div.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+--------------------------------------
//   in_     | input     | in_valid / in_ready   | g_center, g_left, g_right, g_below,
//           |           |                       | g_above, vel_x, vel_y (signed 32 bit)
//   out_    | output    | out_valid / out_ready | g_next (signed 32 bit), saturated
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index (2 bit), cfg_data (32 bit)
//
// One point enters per cycle while the output register holds no beat that is not taken.
// The pipeline is the 8-stage square root and the 8-stage divider in series,
// plus four stages of differences and squares ahead of them and six stages of
// velocity correction, upwind products and the Euler step behind them.
// All stages advance together; they hold only while the output register has a
// beat that is not taken, so no beat is lost or repeated.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. The configuration port is always ready.

module level_set_upwind_point_update_core import lsu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_g_center,
  input  logic signed [31:0] in_g_left,
  input  logic signed [31:0] in_g_right,
  input  logic signed [31:0] in_g_below,
  input  logic signed [31:0] in_g_above,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_g_next,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Stage numbering: stage 1 holds the difference products, stage 4 the squared
  // magnitude, stage NST the output register.
  localparam int CAR_N = ISQ_STAGES + DIV_STAGES + 1;
  localparam int NST   = 4 + ISQ_STAGES + DIV_STAGES + 6;

  typedef struct packed {
    logic [3:0][63:0] prod;
    logic [3:0]       neg;
    logic [31:0]      gc;
    logic [31:0]      ux;
    logic [31:0]      vy;
  } s1_t;

  typedef struct packed {
    logic [3:0][31:0] dif;
    logic [31:0]      gx;
    logic [31:0]      gy;
    logic [31:0]      gc;
    logic [31:0]      ux;
    logic [31:0]      vy;
    logic             flag;
  } s2_t;

  typedef struct packed {
    logic [63:0]      sqx;
    logic [63:0]      sqy;
    logic [63:0]      numx;
    logic [63:0]      numy;
    logic [3:0][31:0] dif;
    logic [31:0]      gc;
    logic [31:0]      ux;
    logic [31:0]      vy;
    logic             gxn;
    logic             gyn;
    logic             flag;
  } s3_t;

  // Payload that rides alongside the square root and the divider.
  typedef struct packed {
    logic [63:0]      numx;
    logic [63:0]      numy;
    logic [3:0][31:0] dif;
    logic [31:0]      gc;
    logic [31:0]      ux;
    logic [31:0]      vy;
    logic             gxn;
    logic             gyn;
    logic             nz;
    logic             flag;
  } car_t;

  typedef struct packed {
    logic [3:0][31:0] dif;
    logic [31:0]      gc;
    logic [31:0]      ux;
    logic [31:0]      vy;
    logic             flag;
  } s21_t;

  typedef struct packed {
    logic [63:0] px;
    logic [63:0] py;
    logic        negx;
    logic        negy;
    logic [31:0] gc;
    logic        flag;
  } s22_t;

  typedef struct packed {
    logic [63:0] rate;
    logic [31:0] gc;
    logic        flag;
  } s23_t;

  typedef struct packed {
    logic [32:0] hi;
    logic [31:0] lo;
    logic        big;
    logic        rneg;
    logic [31:0] gc;
    logic        flag;
  } s24_t;

  typedef struct packed {
    logic [63:0] ph;
    logic [63:0] pl;
    logic        big;
    logic        rneg;
    logic [31:0] gc;
    logic        flag;
  } s25_t;

  // Configuration registers.
  logic [30:0] inv_dx_r;
  logic [30:0] inv_dy_r;
  logic [30:0] ts_r;
  logic [31:0] fs_r;

  logic           en;
  logic [NST:1]   vld_r;
  s1_t            s1_r,  s1_nxt;
  s2_t            s2_r,  s2_nxt;
  s3_t            s3_r,  s3_nxt;
  logic [63:0]    msq_r, msq_nxt;
  car_t           car_nxt;
  car_t           car_r [CAR_N];
  logic [31:0]    root;
  logic [31:0]    qx;
  logic [31:0]    qy;
  s21_t           s21_r, s21_nxt;
  s22_t           s22_r, s22_nxt;
  s23_t           s23_r, s23_nxt;
  s24_t           s24_r, s24_nxt;
  s25_t           s25_r, s25_nxt;
  logic [31:0]    g_next_r, g_next_nxt;
  logic           sat_r, sat_nxt;

  // The whole pipe moves unless the output holds a beat that is not taken.
  assign en        = !vld_r[NST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST];
  assign out_g_next    = g_next_r;
  assign out_saturated = sat_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_dx_r <= RST_INV_DX;
      inv_dy_r <= RST_INV_DY;
      ts_r     <= RST_TIME_STEP;
      fs_r     <= RST_FLAME_SPEED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_DX:      inv_dx_r <= cfg_data[30:0];
        REG_INV_DY:      inv_dy_r <= cfg_data[30:0];
        REG_TIME_STEP:   ts_r     <= cfg_data[30:0];
        REG_FLAME_SPEED: fs_r     <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:1], in_valid};
    end
  end

  // Stage 1: one-sided differences times the reciprocal spacing, as magnitude and sign.
  always_comb begin
    logic [32:0] d [4];
    d[0] = {in_g_center[31], in_g_center} - {in_g_left[31], in_g_left};
    d[1] = {in_g_right[31], in_g_right} - {in_g_center[31], in_g_center};
    d[2] = {in_g_center[31], in_g_center} - {in_g_below[31], in_g_below};
    d[3] = {in_g_above[31], in_g_above} - {in_g_center[31], in_g_center};
    for (int k = 0; k < 4; k++) begin
      s1_nxt.prod[k] = 64'(abs33(d[k])) * 64'((k < 2) ? inv_dx_r : inv_dy_r);
      s1_nxt.neg[k]  = d[k][32];
    end
    s1_nxt.gc = in_g_center;
    s1_nxt.ux = in_vel_x;
    s1_nxt.vy = in_vel_y;
  end

  // Stage 2: scale back, clip each difference to 32 bits and average the pairs.
  always_comb begin
    logic [63:0] m;
    logic [32:0] sx;
    logic [32:0] sy;
    s2_nxt.flag = 1'b0;
    for (int k = 0; k < 4; k++) begin
      m = s1_r.prod[k] >> FRAC_BITS;
      if (!s1_r.neg[k]) begin
        if (m > 64'(S32_MAX)) begin
          s2_nxt.dif[k] = S32_MAX;
          s2_nxt.flag   = 1'b1;
        end else begin
          s2_nxt.dif[k] = m[31:0];
        end
      end else begin
        if (m > 64'(S32_MIN)) begin
          s2_nxt.dif[k] = S32_MIN;
          s2_nxt.flag   = 1'b1;
        end else begin
          s2_nxt.dif[k] = 32'd0 - m[31:0];
        end
      end
    end
    // Halving rounds toward zero: add one to a negative sum before the shift.
    sx = {s2_nxt.dif[0][31], s2_nxt.dif[0]} + {s2_nxt.dif[1][31], s2_nxt.dif[1]};
    sy = {s2_nxt.dif[2][31], s2_nxt.dif[2]} + {s2_nxt.dif[3][31], s2_nxt.dif[3]};
    sx = sx + 33'(sx[32]);
    sy = sy + 33'(sy[32]);
    s2_nxt.gx = sx[32:1];
    s2_nxt.gy = sy[32:1];
    s2_nxt.gc = s1_r.gc;
    s2_nxt.ux = s1_r.ux;
    s2_nxt.vy = s1_r.vy;
  end

  // Stage 3: squares of the gradient and the numerators of the normal term.
  always_comb begin
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] sm;
    ax = abs32(s2_r.gx);
    ay = abs32(s2_r.gy);
    sm = abs32(fs_r);
    s3_nxt.sqx  = 64'(ax) * 64'(ax);
    s3_nxt.sqy  = 64'(ay) * 64'(ay);
    s3_nxt.numx = 64'(sm) * 64'(ax);
    s3_nxt.numy = 64'(sm) * 64'(ay);
    s3_nxt.dif  = s2_r.dif;
    s3_nxt.gc   = s2_r.gc;
    s3_nxt.ux   = s2_r.ux;
    s3_nxt.vy   = s2_r.vy;
    s3_nxt.gxn  = s2_r.gx[31];
    s3_nxt.gyn  = s2_r.gy[31];
    s3_nxt.flag = s2_r.flag;
  end

  // Stage 4: squared magnitude; a zero value means the normal term is skipped.
  always_comb begin
    msq_nxt      = s3_r.sqx + s3_r.sqy;
    car_nxt.numx = s3_r.numx;
    car_nxt.numy = s3_r.numy;
    car_nxt.dif  = s3_r.dif;
    car_nxt.gc   = s3_r.gc;
    car_nxt.ux   = s3_r.ux;
    car_nxt.vy   = s3_r.vy;
    car_nxt.gxn  = s3_r.gxn;
    car_nxt.gyn  = s3_r.gyn;
    car_nxt.nz   = (msq_nxt != '0);
    car_nxt.flag = s3_r.flag;
  end

  lsu_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (msq_r),
    .root (root)
  );

  // The root arrives together with car_r[ISQ_STAGES]; quotients with the last entry.
  lsu_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (car_r[ISQ_STAGES].numx),
    .den (root),
    .quo (qx)
  );

  lsu_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (car_r[ISQ_STAGES].numy),
    .den (root),
    .quo (qy)
  );

  // Velocity correction: subtract flame speed times the unit normal, clipped.
  always_comb begin
    logic [33:0] tx;
    logic [33:0] ty;
    logic [32:0] rx;
    logic [32:0] ry;
    car_t        c;
    c  = car_r[CAR_N-1];
    tx = (fs_r[31] ^ c.gxn) ? (34'd0 - {2'b00, qx}) : {2'b00, qx};
    ty = (fs_r[31] ^ c.gyn) ? (34'd0 - {2'b00, qy}) : {2'b00, qy};
    rx = sat32($signed({{4{c.ux[31]}}, c.ux}) - $signed({{2{tx[33]}}, tx}));
    ry = sat32($signed({{4{c.vy[31]}}, c.vy}) - $signed({{2{ty[33]}}, ty}));
    s21_nxt.dif = c.dif;
    s21_nxt.gc  = c.gc;
    if (c.nz) begin
      s21_nxt.ux   = rx[31:0];
      s21_nxt.vy   = ry[31:0];
      s21_nxt.flag = c.flag | rx[32] | ry[32];
    end else begin
      s21_nxt.ux   = c.ux;
      s21_nxt.vy   = c.vy;
      s21_nxt.flag = c.flag;
    end
  end

  // Upwind products: a positive velocity takes the backward difference, a
  // negative one the forward difference; zero velocity gives a zero product.
  always_comb begin
    logic [31:0] dx;
    logic [31:0] dy;
    dx = s21_r.ux[31] ? s21_r.dif[1] : s21_r.dif[0];
    dy = s21_r.vy[31] ? s21_r.dif[3] : s21_r.dif[2];
    s22_nxt.px   = 64'(abs32(s21_r.ux)) * 64'(abs32(dx));
    s22_nxt.py   = 64'(abs32(s21_r.vy)) * 64'(abs32(dy));
    s22_nxt.negx = s21_r.ux[31] ^ dx[31];
    s22_nxt.negy = s21_r.vy[31] ^ dy[31];
    s22_nxt.gc   = s21_r.gc;
    s22_nxt.flag = s21_r.flag;
  end

  // Rate: each product is scaled back toward zero before the two are summed.
  always_comb begin
    logic [63:0] tx;
    logic [63:0] ty;
    tx = s22_r.px >> FRAC_BITS;
    ty = s22_r.py >> FRAC_BITS;
    tx = s22_r.negx ? (64'd0 - tx) : tx;
    ty = s22_r.negy ? (64'd0 - ty) : ty;
    s23_nxt.rate = tx + ty;
    s23_nxt.gc   = s22_r.gc;
    s23_nxt.flag = s22_r.flag;
  end

  // Split the rate magnitude into integer and fraction parts.
  always_comb begin
    logic [63:0] rm;
    logic [63:0] hi;
    rm = s23_r.rate[63] ? (64'd0 - s23_r.rate) : s23_r.rate;
    hi = rm >> FRAC_BITS;
    s24_nxt.hi   = hi[32:0];
    s24_nxt.lo   = 32'(rm[FRAC_BITS-1:0]);
    s24_nxt.big  = (hi > HI_LIMIT);
    s24_nxt.rneg = s23_r.rate[63];
    s24_nxt.gc   = s23_r.gc;
    s24_nxt.flag = s23_r.flag;
  end

  // Time step products; a zero time step forces a zero step even for a huge rate.
  always_comb begin
    s25_nxt.ph   = 64'(ts_r) * 64'(s24_r.hi);
    s25_nxt.pl   = 64'(ts_r) * 64'(s24_r.lo);
    s25_nxt.big  = s24_r.big && (ts_r != '0);
    s25_nxt.rneg = s24_r.rneg;
    s25_nxt.gc   = s24_r.gc;
    s25_nxt.flag = s24_r.flag;
  end

  // Euler step, capped at 2^33, then the final clip into the output register.
  always_comb begin
    logic [63:0] step;
    logic [35:0] sw;
    logic [35:0] gw;
    logic [32:0] r;
    step = s25_r.ph + (s25_r.pl >> FRAC_BITS);
    if (s25_r.big || step > STEP_CAP) begin
      step = STEP_CAP;
    end
    sw = step[35:0];
    gw = {{4{s25_r.gc[31]}}, s25_r.gc};
    gw = s25_r.rneg ? (gw + sw) : (gw - sw);
    r  = sat32($signed(gw));
    g_next_nxt = r[31:0];
    sat_nxt    = s25_r.flag | r[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      msq_r    <= msq_nxt;
      car_r[0] <= car_nxt;
      for (int k = 1; k < CAR_N; k++) begin
        car_r[k] <= car_r[k-1];
      end
      s21_r    <= s21_nxt;
      s22_r    <= s22_nxt;
      s23_r    <= s23_nxt;
      s24_r    <= s24_nxt;
      s25_r    <= s25_nxt;
      g_next_r <= g_next_nxt;
      sat_r    <= sat_nxt;
    end
  end

  // An accepted beat always lands in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[1])
    else $error("accepted beat did not enter stage 1");

  // While the output is stalled nothing in the pipe may move.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  // A nonzero squared magnitude has a nonzero root, so the divisor is never zero where the quotient is used.
  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4 + ISQ_STAGES] && car_r[ISQ_STAGES].nz |-> root != '0)
    else $error("zero root for nonzero gradient");

  // Each normal component is bounded by the flame speed magnitude.
  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4 + ISQ_STAGES + DIV_STAGES] && car_r[CAR_N-1].nz |->
      qx <= abs32(fs_r) && qy <= abs32(fs_r))
    else $error("normal term exceeds flame speed");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for level_set_upwind_point_update_core.
// Depends on lsu_pkg and the block's RTL. Every accepted point is predicted in
// the bench and compared with the result beat that leaves in order.
module tb;
  import lsu_pkg::*;

  localparam int FRAC_BITS = 16;
  // Margin waited after the last predicted update has left the block.
  localparam int DRAIN_CYCLES = 40;
  // Cycles without any accepted beat before the run is abandoned.
  localparam int IDLE_LIMIT = 20000;

  // One stencil point as it enters the block.
  typedef struct packed {
    logic [31:0] g_center, g_left, g_right, g_below, g_above, vel_x, vel_y;
  } point_t;

  // One updated value as it leaves the block.
  typedef struct packed {
    logic [31:0] g_next;
    logic        saturated;
  } update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_g_center = '0, in_g_left = '0, in_g_right = '0, in_g_below = '0;
  logic [31:0] in_g_above = '0, in_vel_x = '0, in_vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_g_next;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_INV_DX;
  logic [31:0] cfg_data = '0;

  level_set_upwind_point_update_core #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_g_center(in_g_center), .in_g_left(in_g_left), .in_g_right(in_g_right),
    .in_g_below(in_g_below), .in_g_above(in_g_above),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_g_next(out_g_next), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The bench's own copy of the configuration registers.
  logic [63:0] spacing_x, spacing_y, step_len;
  longint      front_speed;

  update_t pending_updates[$];
  int      error_count = 0;
  int      send_idle_pct = 0;   // chance in a hundred that the sender is idle in a cycle
  int      recv_stall_pct = 0;  // chance in a hundred that the receiver stalls
  int      hold_req = 0;        // request for a long receiver hold-off
  int      hold_left = 0;
  int      quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction. Arithmetic is done in 64 bits, on magnitudes with explicit signs
  // where it multiplies or divides, truncating toward zero, as the block is specified.
  // ---------------------------------------------------------------------------
  function automatic longint sext(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [63:0] mag(longint x);
    return (x < 0) ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  function automatic longint with_sign(logic [63:0] m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(longint x, inout bit flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Fixed-point product a*b/2^FRAC_BITS.
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] m;
    m = (mag(a) * mag(b)) >> FRAC_BITS;
    return with_sign(m, (a < 0) != (b < 0));
  endfunction

  // Bitwise floor square root, 32 iterations.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic update_t predict_update(point_t p);
    bit          flag;
    longint      gc, ux, vy, xm, xp, ym, yp, gx, gy, tx, ty, rate, g;
    logic [63:0] msq, m, sm, rm, hi, lo, stp;
    update_t     r;
    flag = 1'b0;
    gc = sext(p.g_center);
    ux = sext(p.vel_x);
    vy = sext(p.vel_y);
    xm = clip32(fx_mul(gc - sext(p.g_left), longint'(spacing_x)), flag);
    xp = clip32(fx_mul(sext(p.g_right) - gc, longint'(spacing_x)), flag);
    ym = clip32(fx_mul(gc - sext(p.g_below), longint'(spacing_y)), flag);
    yp = clip32(fx_mul(sext(p.g_above) - gc, longint'(spacing_y)), flag);
    gx = (xm + xp) / 2;
    gy = (ym + yp) / 2;
    msq = mag(gx) * mag(gx) + mag(gy) * mag(gy);
    // A vanishing gradient leaves the velocity without a normal correction.
    if (msq != 0) begin
      m = floor_sqrt(msq);
      sm = mag(front_speed);
      tx = with_sign((sm * mag(gx)) / m, (front_speed < 0) != (gx < 0));
      ty = with_sign((sm * mag(gy)) / m, (front_speed < 0) != (gy < 0));
      ux = clip32(ux - tx, flag);
      vy = clip32(vy - ty, flag);
    end
    rate = fx_mul((ux > 0) ? ux : 0, xm) + fx_mul((ux < 0) ? ux : 0, xp)
         + fx_mul((vy > 0) ? vy : 0, ym) + fx_mul((vy < 0) ? vy : 0, yp);
    rm = mag(rate);
    hi = rm >> FRAC_BITS;
    lo = rm & ((64'd1 << FRAC_BITS) - 1);
    // The step is capped at 2^33 so that the final clip still flags it.
    if (step_len == 0) begin
      stp = 0;
    end else if (hi > HI_LIMIT) begin
      stp = STEP_CAP;
    end else begin
      stp = step_len * hi + ((step_len * lo) >> FRAC_BITS);
      if (stp > STEP_CAP) stp = STEP_CAP;
    end
    g = clip32(gc - with_sign(stp, rate < 0), flag);
    r.g_next = g[31:0];
    r.saturated = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change only at rising edges; handshakes are sampled at the
  // falling edge, where every input and output is settled for the next edge.
  // ---------------------------------------------------------------------------
  task automatic send_point(point_t p);
    bit taken;
    in_valid <= 1'b1;
    in_g_center <= p.g_center;
    in_g_left <= p.g_left;
    in_g_right <= p.g_right;
    in_g_below <= p.g_below;
    in_g_above <= p.g_above;
    in_vel_x <= p.vel_x;
    in_vel_y <= p.vel_y;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    // The configuration is stable while points are in flight.
    pending_updates.push_back(predict_update(p));
    // Each cycle is idle with the given chance, so idle cycles make up that share.
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop sending and wait until every predicted update has left the block.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    bit taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INV_DX: spacing_x = {33'd0, val[30:0]};
      REG_INV_DY: spacing_y = {33'd0, val[30:0]};
      REG_TIME_STEP: step_len = {33'd0, val[30:0]};
      REG_FLAME_SPEED: front_speed = sext(val);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] dx, logic [31:0] dy, logic [31:0] dt,
                            logic [31:0] speed);
    write_reg(REG_INV_DX, dx);
    write_reg(REG_INV_DY, dy);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_FLAME_SPEED, speed);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus shapes.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] corner_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      4: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly smooth fields, as a real level set would give, with some noise.
  function automatic point_t random_point();
    point_t p;
    int     kind;
    int     c;
    kind = $urandom_range(99);
    if (kind < 70) begin
      c = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      p.g_center = c;
      p.g_left   = c - ($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      p.g_right  = c + ($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      p.g_below  = c - ($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      p.g_above  = c + ($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      p.vel_x    = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      p.vel_y    = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      // Flat stencils exercise the path without a normal correction.
      if ($urandom_range(9) == 0) begin
        p.g_left = c; p.g_right = c; p.g_below = c; p.g_above = c;
      end
    end else if (kind < 85) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      p = {corner_value(), corner_value(), corner_value(), corner_value(),
           corner_value(), corner_value(), corner_value()};
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  always @(negedge clk) begin
    update_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected beat g_next", out_g_next, '0);
      end else begin
        want = pending_updates.pop_front();
        if (out_g_next !== want.g_next)
          report_mismatch("g_next", out_g_next, want.g_next);
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", {31'd0, out_saturated}, {31'd0, want.saturated});
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel, configuration included.
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults;
    point_t p;
    // The register defaults must be in effect without any write.
    p = '0;
    send_point(p);
    p = {32'h0001_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_8000,
         32'h0001_0000, 32'hFFFF_0000};
    send_point(p);
    drain();
  endtask

  task automatic test_directed;
    point_t p;
    set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    p = {7{32'h7FFF_FFFF}};
    send_point(p);
    p = {7{32'h8000_0000}};
    send_point(p);
    // Largest differences in both directions saturate the one-sided terms.
    p = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000};
    send_point(p);
    p = {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF};
    send_point(p);
    // A single unit difference averages to a zero gradient, so the normal correction is skipped.
    p = {32'd1, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0};
    send_point(p);
    // Large rate and a huge time step clip the step.
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    p = {32'h0000_0000, 32'hC000_0000, 32'h4000_0000, 32'hC000_0000, 32'h4000_0000,
         32'h7FFF_FFFF, 32'h8000_0000};
    send_point(p);
    p = {32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8765_4321, 32'h0000_0100,
         32'hFFFF_FFFF, 32'h0000_0001};
    send_point(p);
    // Zero spacing registers and a zero time step.
    set_config(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    p = {32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0010_0000,
         32'h0004_0000, 32'hFFFC_0000};
    send_point(p);
    set_config(32'd1, 32'h0001_0000, 32'd1, 32'hFFFF_FFFF);
    p = {32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 32'h0000_4000, 32'h0000_C000,
         32'h0002_0000, 32'h0002_0000};
    send_point(p);
    p = {32'hFFFF_0000, 32'h0000_0000, 32'hFFFE_0000, 32'hFFFF_8000, 32'hFFFE_8000,
         32'hFFFE_0000, 32'hFFFE_0000};
    send_point(p);
    drain();
  endtask

  // One phase of random points under a given configuration and idling mix.
  task automatic test_random_phase(int count, int tx_pct, int rx_pct);
    send_idle_pct = tx_pct;
    recv_stall_pct = rx_pct;
    for (int i = 0; i < count; i++) send_point(random_point());
    drain();
  endtask

  // The receiver holds off for a long stretch while points keep coming, so the
  // pipeline fills and in_ready must drop without losing a beat.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 400;
    for (int i = 0; i < 80; i++) send_point(random_point());
    drain();
  endtask

  initial begin
    spacing_x = {33'd0, RST_INV_DX};
    spacing_y = {33'd0, RST_INV_DY};
    step_len = {33'd0, RST_TIME_STEP};
    front_speed = sext(RST_FLAME_SPEED);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();

    set_config(32'h0001_0000, 32'h0001_0000, 32'd655, 32'h0001_0000);
    test_random_phase(200, 0, 0);
    set_config(32'h0004_0000, 32'h0000_4000, 32'h0000_8000, 32'hFFFE_0000);
    test_random_phase(150, 80, 0);
    set_config($urandom, $urandom, $urandom, $urandom);
    test_random_phase(150, 0, 80);
    set_config(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    test_random_phase(150, 31, 31);
    set_config($urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000),
               $urandom_range(32'h0001_0000), $urandom);
    test_random_phase(170, 31, 31);
    test_backpressure();

    drain();
    if (error_count == 0 && pending_updates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== level_set_upwind_point_update_core.f =====
sv/lsu_pkg.sv
sv/lsu_isqrt.sv
sv/lsu_div.sv
sv/level_set_upwind_point_update_core.sv
tb/tb.sv
